### rtl/fp_pkg.sv
// Shared types and codes for the Farey parents block.
`timescale 1ns / 1ps
`default_nettype none
package fp_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_G_TEST, ST_G_WAIT, ST_P_WAIT, ST_Q_START, ST_Q_WAIT,
    ST_B_INIT, ST_B_TEST, ST_B_WAIT, ST_B_STEP, ST_CMP_A, ST_CMP_B, ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_CHECK, CMD_DIV_G, CMD_G_STEP, CMD_DIV_P, CMD_SET_P,
    CMD_DIV_Q, CMD_SET_Q, CMD_B_INIT, CMD_DIV_B, CMD_B_MUL, CMD_B_STEP,
    CMD_MUL_A, CMD_MUL_B, CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic div_start;
    cmd_e op;
  } ctrl_t;

  typedef struct packed {
    logic bad;
    logic div_busy;
    logic v_zero;
    logic r_zero;
  } stat_t;
endpackage
`default_nettype wire

### rtl/fp_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fp_divider #(
  parameter int W = 31
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              busy_o,
  output logic [W-1:0]      quo_o,
  output logic [W-1:0]      rem_o
);
  localparam int CW = $clog2(W + 1);
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  q_q, q_d, r_q, r_d, dv_q, dv_d;
  logic [W:0]    trial;
  logic          busy_q, busy_d;

  always_comb begin
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    dv_d   = dv_q;
    busy_d = busy_q;
    trial  = {r_q, q_q[W-1]};
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = '0;
      dv_d   = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        r_d = W'(trial - {1'b0, dv_q});
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = trial[W-1:0];
        q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    r_q  <= r_d;
    dv_q <= dv_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = q_q;
  assign rem_o  = r_q;
endmodule
`default_nettype wire

### rtl/fp_datapath.sv
// Datapath: operand registers, divider, multiplier and result fields.
`timescale 1ns / 1ps
`default_nettype none
module fp_datapath #(
  parameter int W = 31
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire fp_pkg::ctrl_t ctrl_i,
  output fp_pkg::stat_t     stat_o,
  input  wire logic [W-1:0] numer_i,
  input  wire logic [W-1:0] denom_i,
  output logic              bad_o,
  output logic [W-1:0]      rn_o,
  output logic [W-1:0]      rd_o,
  output logic [W-1:0]      ln_o,
  output logic [W-1:0]      ld_o,
  output logic [W-1:0]      gn_o,
  output logic [W-1:0]      gd_o
);
  logic [W-1:0] p_q, q_q, u_q, v_q, rold_q, rcur_q, xo_q, xc_q, yo_q, yc_q;
  logic [W-1:0] mx_q, my_q;
  logic [2*W-1:0] pa_q, pb_q;
  logic [W-1:0] dvd, dvs, quo, rem, a_v, b_v;
  logic [2*W-1:0] prod;
  logic bad_q, busy;
  logic [W-1:0] mul_a, mul_b;

  always_comb begin
    dvd = u_q;
    dvs = v_q;
    case (ctrl_i.op)
      fp_pkg::CMD_DIV_G: begin dvd = u_q;    dvs = v_q; end
      fp_pkg::CMD_DIV_P: begin dvd = p_q;    dvs = u_q; end
      fp_pkg::CMD_DIV_Q: begin dvd = q_q;    dvs = u_q; end
      fp_pkg::CMD_DIV_B: begin dvd = rold_q; dvs = rcur_q; end
      default:           begin dvd = u_q;    dvs = v_q; end
    endcase
  end

  fp_divider #(.W(W)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(ctrl_i.div_start),
    .dividend_i(dvd), .divisor_i(dvs), .busy_o(busy), .quo_o(quo), .rem_o(rem)
  );

  assign a_v = p_q - yo_q;
  assign b_v = q_q - xo_q;
  always_comb begin
    mul_a = a_v;
    mul_b = xo_q;
    case (ctrl_i.op)
      fp_pkg::CMD_MUL_B: begin mul_a = yo_q; mul_b = b_v; end
      default:           begin mul_a = a_v;  mul_b = xo_q; end
    endcase
  end
  assign prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bad_q <= 1'b0;
    else if (ctrl_i.op == fp_pkg::CMD_CHECK) bad_q <= (p_q == '0) || (p_q >= q_q);
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      fp_pkg::CMD_LOAD: begin
        p_q <= numer_i; q_q <= denom_i; u_q <= denom_i; v_q <= numer_i;
      end
      fp_pkg::CMD_G_STEP: begin u_q <= v_q; v_q <= rem; end
      fp_pkg::CMD_SET_P: p_q <= quo;
      fp_pkg::CMD_SET_Q: q_q <= quo;
      fp_pkg::CMD_B_INIT: begin
        rold_q <= q_q; rcur_q <= p_q;
        xo_q <= '0; xc_q <= W'(1); yo_q <= W'(1); yc_q <= '0;
      end
      fp_pkg::CMD_B_MUL: begin
        mx_q  <= W'({{W{1'b0}}, quo} * {{W{1'b0}}, xc_q});
        my_q  <= W'({{W{1'b0}}, quo} * {{W{1'b0}}, yc_q});
        rold_q <= rcur_q; rcur_q <= rem;
      end
      fp_pkg::CMD_B_STEP: begin
        xo_q <= xc_q; xc_q <= xo_q + mx_q;
        yo_q <= yc_q; yc_q <= yo_q + my_q;
      end
      fp_pkg::CMD_MUL_A: pa_q <= prod;
      fp_pkg::CMD_MUL_B: pb_q <= prod;
      fp_pkg::CMD_FINISH: begin
        if (bad_q) begin
          ln_o <= '0; ld_o <= '0; gn_o <= '0; gd_o <= '0; rn_o <= '0; rd_o <= '0;
        end else if (pa_q > pb_q) begin
          ln_o <= yo_q; ld_o <= xo_q; gn_o <= a_v; gd_o <= b_v;
          rn_o <= p_q; rd_o <= q_q;
        end else begin
          ln_o <= a_v; ld_o <= b_v; gn_o <= yo_q; gd_o <= xo_q;
          rn_o <= p_q; rd_o <= q_q;
        end
      end
      default: ;
    endcase
  end

  assign bad_o = bad_q;
  assign stat_o.bad = bad_q;
  assign stat_o.div_busy = busy;
  assign stat_o.v_zero = (v_q == '0);
  assign stat_o.r_zero = (rcur_q == '0);
endmodule
`default_nettype wire

### rtl/fp_ctrl.sv
// Sequencer for the gcd, reduction, Bezout and compare phases.
`timescale 1ns / 1ps
`default_nettype none
module fp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          out_free_i,
  input  wire fp_pkg::stat_t stat_i,
  output fp_pkg::ctrl_t      ctrl_o,
  output logic               ready_o,
  output logic               done_o
);
  fp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o.op = fp_pkg::CMD_NONE;
    ctrl_o.div_start = 1'b0;
    ready_o = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      fp_pkg::ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          ctrl_o.op = fp_pkg::CMD_LOAD;
          state_d = fp_pkg::ST_CHECK;
        end
      end
      fp_pkg::ST_CHECK: begin
        ctrl_o.op = fp_pkg::CMD_CHECK;
        state_d = fp_pkg::ST_G_TEST;
      end
      fp_pkg::ST_G_TEST: begin
        if (stat_i.bad) begin
          state_d = fp_pkg::ST_FINISH;
        end else if (stat_i.v_zero) begin
          ctrl_o.op = fp_pkg::CMD_DIV_P;
          ctrl_o.div_start = 1'b1;
          state_d = fp_pkg::ST_P_WAIT;
        end else begin
          ctrl_o.op = fp_pkg::CMD_DIV_G;
          ctrl_o.div_start = 1'b1;
          state_d = fp_pkg::ST_G_WAIT;
        end
      end
      fp_pkg::ST_G_WAIT: begin
        if (!stat_i.div_busy) begin
          ctrl_o.op = fp_pkg::CMD_G_STEP;
          state_d = fp_pkg::ST_G_TEST;
        end
      end
      fp_pkg::ST_P_WAIT: begin
        if (!stat_i.div_busy) begin
          ctrl_o.op = fp_pkg::CMD_SET_P;
          state_d = fp_pkg::ST_Q_START;
        end
      end
      fp_pkg::ST_Q_START: begin
        ctrl_o.op = fp_pkg::CMD_DIV_Q;
        ctrl_o.div_start = 1'b1;
        state_d = fp_pkg::ST_Q_WAIT;
      end
      fp_pkg::ST_Q_WAIT: begin
        if (!stat_i.div_busy) begin
          ctrl_o.op = fp_pkg::CMD_SET_Q;
          state_d = fp_pkg::ST_B_INIT;
        end
      end
      fp_pkg::ST_B_INIT: begin
        ctrl_o.op = fp_pkg::CMD_B_INIT;
        state_d = fp_pkg::ST_B_TEST;
      end
      fp_pkg::ST_B_TEST: begin
        if (stat_i.r_zero) begin
          state_d = fp_pkg::ST_CMP_A;
        end else begin
          ctrl_o.op = fp_pkg::CMD_DIV_B;
          ctrl_o.div_start = 1'b1;
          state_d = fp_pkg::ST_B_WAIT;
        end
      end
      fp_pkg::ST_B_WAIT: begin
        if (!stat_i.div_busy) begin
          ctrl_o.op = fp_pkg::CMD_B_MUL;
          state_d = fp_pkg::ST_B_STEP;
        end
      end
      fp_pkg::ST_B_STEP: begin
        ctrl_o.op = fp_pkg::CMD_B_STEP;
        state_d = fp_pkg::ST_B_TEST;
      end
      fp_pkg::ST_CMP_A: begin
        ctrl_o.op = fp_pkg::CMD_MUL_A;
        state_d = fp_pkg::ST_CMP_B;
      end
      fp_pkg::ST_CMP_B: begin
        ctrl_o.op = fp_pkg::CMD_MUL_B;
        state_d = fp_pkg::ST_FINISH;
      end
      fp_pkg::ST_FINISH: begin
        if (out_free_i) begin
          ctrl_o.op = fp_pkg::CMD_FINISH;
          done_o = 1'b1;
          state_d = fp_pkg::ST_IDLE;
        end
      end
      default: state_d = fp_pkg::ST_IDLE;
    endcase
  end

  property p_done_free;
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> out_free_i;
  endproperty
  a_done_free: assert property (p_done_free) else $error("result written into a full slot");
  property p_start_idle;
    @(posedge clk_i) disable iff (!rst_ni) start_i && ready_o |=> state_q == fp_pkg::ST_CHECK;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("load did not enter check");
  property p_div_start;
    @(posedge clk_i) disable iff (!rst_ni) ctrl_o.div_start |-> !stat_i.div_busy;
  endproperty
  a_div_start: assert property (p_div_start) else $error("divider restarted while busy");
  property p_done;
    @(posedge clk_i) disable iff (!rst_ni) done_o |=> state_q == fp_pkg::ST_IDLE;
  endproperty
  a_done: assert property (p_done) else $error("finish did not return to idle");
endmodule
`default_nettype wire

### rtl/farey_parents.sv
// Top level: Farey-tree parents of a proper fraction.
// Throughput: one beat at a time; the next input is taken once the result is in the
//   output register, while that result may still wait to be taken.
// Reset: asynchronous active low; clears control state and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module farey_parents #(
  parameter int DATA_WIDTH = 31
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // numer, denom
  input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // bad_input, reduced_numer, reduced_denom, lesser_numer, lesser_denom,
  // greater_numer, greater_denom
  output logic [((6*DATA_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);
  localparam int W = DATA_WIDTH;
  localparam int OW = ((6*W+1+7)/8)*8;
  fp_pkg::ctrl_t ctrl;
  fp_pkg::stat_t stat;
  logic ready, done, bad;
  logic [W-1:0] rn, rd, ln, ld, gn, gd;
  logic ovalid_q;

  fp_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(s_axis_tvalid),
    .out_free_i(!ovalid_q || m_axis_tready), .stat_i(stat), .ctrl_o(ctrl),
    .ready_o(ready), .done_o(done)
  );

  fp_datapath #(.W(W)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .stat_o(stat),
    .numer_i(s_axis_tdata[W-1:0]), .denom_i(s_axis_tdata[2*W-1:W]),
    .bad_o(bad), .rn_o(rn), .rd_o(rd), .ln_o(ln), .ld_o(ld), .gn_o(gn), .gd_o(gd)
  );

  assign s_axis_tready = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (done) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end
  logic bad_q;
  always_ff @(posedge clk_i) if (done) bad_q <= bad;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = OW'({gd, gn, ld, ln, rd, rn, bad_q});
endmodule
`default_nettype wire
